@@ hw/rtl/hta_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hta_pkg: shared types and constants for the Heron triangle area pipeline
// Holds the result width and the stage control bundle used by the root units.
// ----------------------------------------------------------------------------
package hta_pkg;

  // width of the area result port
  localparam int OUT_W = 39;

  // per-stage control: advance strobe and the valid bit of the word entering
  typedef struct packed {
    logic adv;
    logic vld;
  } hta_ctl_t;

endpackage

@@ hw/rtl/hta_isqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hta_isqrt: pipelined floor square root
// Digit-by-digit restoring root, one result bit per register stage.
// One radicand accepted per advancing cycle.
// ----------------------------------------------------------------------------
module hta_isqrt #(
  parameter int RAD_W = 50
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  hta_pkg::hta_ctl_t      ctl,
  input  logic [RAD_W-1:0]       rad,
  output logic [RAD_W/2-1:0]     root,
  output logic                   root_vld
);

  localparam int K = RAD_W / 2;

  logic [RAD_W-1:0] rad_r  [K-1];
  logic [K:0]       rem_r  [K-1];
  logic [K-1:0]     root_r [K];
  logic             vld_r  [K];

  for (genvar g = 0; g < K; g++) begin : g_stage
    logic [RAD_W-1:0] rad_in;
    logic [K:0]       rem_in;
    logic [K-1:0]     root_in;
    logic             vld_in;
    logic [K+2:0]     rem_t;
    logic [K+2:0]     trial;
    logic [K+2:0]     diff;
    logic             ge;

    if (g == 0) begin : g_first
      assign rad_in  = rad;
      assign rem_in  = '0;
      assign root_in = '0;
      assign vld_in  = ctl.vld;
    end else begin : g_next
      assign rad_in  = rad_r[g-1];
      assign rem_in  = rem_r[g-1];
      assign root_in = root_r[g-1];
      assign vld_in  = vld_r[g-1];
    end

    assign rem_t = {rem_in, rad_in[RAD_W-1 -: 2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign diff  = rem_t - trial;
    assign ge    = (rem_t >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (ctl.adv) begin
        vld_r[g] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.adv) begin
        root_r[g] <= {root_in[K-2:0], ge};
      end
    end

    if (g < K - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (ctl.adv) begin
          rad_r[g] <= {rad_in[RAD_W-3:0], 2'b00};
          rem_r[g] <= ge ? diff[K:0] : rem_t[K:0];
        end
      end
    end
  end

  assign root     = root_r[K-1];
  assign root_vld = vld_r[K-1];

endmodule

@@ hw/rtl/triangle_area_heron.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_area_heron: fixed-point triangle area by Heron's formula
// Streams vertex triples in and area words out, fully pipelined.
// ----------------------------------------------------------------------------
// One triangle enters per clock while the output is not stalled. The pipe
// holds 10 register stages of capture, arithmetic and output plus
// COORD_BITS+FRAC_BITS+1 stages of the side root and 2*COORD_BITS+FRAC_BITS+4
// stages of the area root. Each root unit resolves one bit per stage. A stall
// on the output freezes the whole pipe; ready then drops until the result word
// is taken. Areas wider than 39 bits saturate to all ones.
module triangle_area_heron #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [COORD_BITS-1:0]       in_ax,
  input  logic [COORD_BITS-1:0]       in_ay,
  input  logic [COORD_BITS-1:0]       in_bx,
  input  logic [COORD_BITS-1:0]       in_by_coord,
  input  logic [COORD_BITS-1:0]       in_cx,
  input  logic [COORD_BITS-1:0]       in_cy,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [hta_pkg::OUT_W-1:0]   out_area_fixed
);

  localparam int CB   = COORD_BITS;
  localparam int DW   = CB + 1;                // coordinate difference
  localparam int D2W  = 2 * CB + 2;            // squared distance
  localparam int SRW  = D2W + 2 * FRAC_BITS;   // side radicand
  localparam int KS   = SRW / 2;               // side width
  localparam int SW   = KS + 2;                // perimeter and terms
  localparam int PW   = 4 * SW;                // full product
  localparam int ARW  = PW - 2 * FRAC_BITS - 4;
  localparam int AK   = ARW / 2;
  localparam int OW   = hta_pkg::OUT_W;

  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // stage valids
  logic v0_r, v1_r, v2_r, v3_r, v5_r, v6_r, v7_r, v8_r, v9_r, out_valid_r;
  logic vs_a, vs_b, vs_c, va;

  // stage 0: captured coordinates
  logic [CB-1:0] ax_r, ay_r, bx_r, by_r, cx_r, cy_r;
  // stage 1: differences
  logic signed [DW-1:0] dxa_r, dya_r, dxb_r, dyb_r, dxc_r, dyc_r;
  // stage 2: squares
  logic signed [D2W-1:0] sxa_r, sya_r, sxb_r, syb_r, sxc_r, syc_r;
  // stage 3: squared distances
  logic [D2W-1:0] d2a_r, d2b_r, d2c_r;
  // side roots
  logic [KS-1:0] side_a, side_b, side_c;
  // stage 5: perimeter sum
  logic [SW-1:0] s5_r;
  logic [KS-1:0] sa_r, sb_r, sc_r;
  // stage 6: clamped terms
  logic [SW-1:0] s6_r, ta_r, tb_r, tc_r, ta_nxt, tb_nxt, tc_nxt;
  // stage 7..9: product
  logic [2*SW-1:0] p1_r, p2_r;
  logic [2*SW-1:0] pp_hh_r, pp_hl_r, pp_lh_r, pp_ll_r;
  logic [PW-1:0]   prod_r;
  // area
  logic [AK-1:0]   area_root;
  logic [OW-1:0]   area_sat;
  logic [OW-1:0]   out_area_r;

  hta_pkg::hta_ctl_t side_ctl, area_ctl;
  assign side_ctl = '{adv: adv, vld: v3_r};
  assign area_ctl = '{adv: adv, vld: v9_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      v7_r        <= 1'b0;
      v8_r        <= 1'b0;
      v9_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v0_r        <= in_valid;
      v1_r        <= v0_r;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v5_r        <= vs_a;
      v6_r        <= v5_r;
      v7_r        <= v6_r;
      v8_r        <= v7_r;
      v9_r        <= v8_r;
      out_valid_r <= va;
    end
  end

  // 2*side never exceeds the terms' width; negative differences clamp to zero
  always_comb begin
    ta_nxt = (s5_r >= {1'b0, sa_r, 1'b0}) ? s5_r - {1'b0, sa_r, 1'b0} : '0;
    tb_nxt = (s5_r >= {1'b0, sb_r, 1'b0}) ? s5_r - {1'b0, sb_r, 1'b0} : '0;
    tc_nxt = (s5_r >= {1'b0, sc_r, 1'b0}) ? s5_r - {1'b0, sc_r, 1'b0} : '0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ax_r <= in_ax;
      ay_r <= in_ay;
      bx_r <= in_bx;
      by_r <= in_by_coord;
      cx_r <= in_cx;
      cy_r <= in_cy;

      dxa_r <= $signed({ax_r[CB-1], ax_r}) - $signed({bx_r[CB-1], bx_r});
      dya_r <= $signed({ay_r[CB-1], ay_r}) - $signed({by_r[CB-1], by_r});
      dxb_r <= $signed({bx_r[CB-1], bx_r}) - $signed({cx_r[CB-1], cx_r});
      dyb_r <= $signed({by_r[CB-1], by_r}) - $signed({cy_r[CB-1], cy_r});
      dxc_r <= $signed({cx_r[CB-1], cx_r}) - $signed({ax_r[CB-1], ax_r});
      dyc_r <= $signed({cy_r[CB-1], cy_r}) - $signed({ay_r[CB-1], ay_r});

      sxa_r <= dxa_r * dxa_r;
      sya_r <= dya_r * dya_r;
      sxb_r <= dxb_r * dxb_r;
      syb_r <= dyb_r * dyb_r;
      sxc_r <= dxc_r * dxc_r;
      syc_r <= dyc_r * dyc_r;

      d2a_r <= $unsigned(sxa_r) + $unsigned(sya_r);
      d2b_r <= $unsigned(sxb_r) + $unsigned(syb_r);
      d2c_r <= $unsigned(sxc_r) + $unsigned(syc_r);

      s5_r <= {2'b00, side_a} + {2'b00, side_b} + {2'b00, side_c};
      sa_r <= side_a;
      sb_r <= side_b;
      sc_r <= side_c;

      s6_r <= s5_r;
      ta_r <= ta_nxt;
      tb_r <= tb_nxt;
      tc_r <= tc_nxt;

      p1_r <= s6_r * ta_r;
      p2_r <= tb_r * tc_r;

      // wide product cut into four partial products
      pp_hh_r <= p1_r[2*SW-1:SW] * p2_r[2*SW-1:SW];
      pp_hl_r <= p1_r[2*SW-1:SW] * p2_r[SW-1:0];
      pp_lh_r <= p1_r[SW-1:0]    * p2_r[2*SW-1:SW];
      pp_ll_r <= p1_r[SW-1:0]    * p2_r[SW-1:0];

      prod_r <= {pp_hh_r, {(2*SW){1'b0}}}
              + {{SW{1'b0}}, pp_hl_r, {SW{1'b0}}}
              + {{SW{1'b0}}, pp_lh_r, {SW{1'b0}}}
              + {{(2*SW){1'b0}}, pp_ll_r};

      out_area_r <= area_sat;
    end
  end

  hta_isqrt #(.RAD_W(SRW)) u_side_a (
    .clk(clk), .rst_n(rst_n), .ctl(side_ctl),
    .rad({d2a_r, {(2*FRAC_BITS){1'b0}}}), .root(side_a), .root_vld(vs_a)
  );

  hta_isqrt #(.RAD_W(SRW)) u_side_b (
    .clk(clk), .rst_n(rst_n), .ctl(side_ctl),
    .rad({d2b_r, {(2*FRAC_BITS){1'b0}}}), .root(side_b), .root_vld(vs_b)
  );

  hta_isqrt #(.RAD_W(SRW)) u_side_c (
    .clk(clk), .rst_n(rst_n), .ctl(side_ctl),
    .rad({d2c_r, {(2*FRAC_BITS){1'b0}}}), .root(side_c), .root_vld(vs_c)
  );

  hta_isqrt #(.RAD_W(ARW)) u_area (
    .clk(clk), .rst_n(rst_n), .ctl(area_ctl),
    .rad(prod_r[PW-1:2*FRAC_BITS+4]), .root(area_root), .root_vld(va)
  );

  if (AK > OW) begin : g_sat
    assign area_sat = (|area_root[AK-1:OW]) ? {OW{1'b1}} : area_root[OW-1:0];
  end else begin : g_ext
    assign area_sat = {{(OW-AK){1'b0}}, area_root};
  end

  assign out_valid      = out_valid_r;
  assign out_area_fixed = out_area_r;

  // the three side roots run in lockstep
  a_side_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    (vs_a == vs_b) && (vs_a == vs_c))
    else $error("side root valids out of step");

  // an empty output register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // a finished area reaches the output on the next advance
  a_area_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && va) |=> out_valid)
    else $error("area word lost before output");

endmodule
